// File: design/ita_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ita_pkg: shared types and constants for the integer to ASCII formatter
// Request/response structs, radix and suffix codes, character codes.
// ----------------------------------------------------------------------------
package ita_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned BCD_W = 40;
  localparam int unsigned CNT_W = 6;

  localparam logic [1:0] KIND_DEC = 2'd0;
  localparam logic [1:0] KIND_HEX = 2'd1;
  localparam logic [1:0] KIND_BIN = 2'd2;

  localparam logic [1:0] SUF_NONE  = 2'd0;
  localparam logic [1:0] SUF_CRLF  = 2'd1;
  localparam logic [1:0] SUF_SPACE = 2'd2;
  localparam logic [1:0] SUF_COMMA = 2'd3;

  localparam logic [6:0] CH_ZERO      = 7'd48;
  localparam logic [6:0] CH_ALPHA_OFS = 7'd55;
  localparam logic [6:0] CH_MINUS     = 7'd45;
  localparam logic [6:0] CH_X         = 7'd120;
  localparam logic [6:0] CH_B         = 7'd98;
  localparam logic [6:0] CH_CR        = 7'd13;
  localparam logic [6:0] CH_LF        = 7'd10;
  localparam logic [6:0] CH_SPACE     = 7'd32;
  localparam logic [6:0] CH_COMMA     = 7'd44;

  typedef struct packed {
    logic [1:0]       kind;
    logic [VAL_W-1:0] value;
    logic [1:0]       suffix;
  } req_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       is_final;
  } rsp_t;

  typedef struct packed {
    logic             start;
    logic [1:0]       kind;
    logic [1:0]       suffix;
    logic             neg;
    logic [BCD_W-1:0] body;
    logic [CNT_W-1:0] cnt;
  } emit_cmd_t;

  function automatic logic [3:0] bcd_adj(input logic [3:0] d);
    bcd_adj = (d > 4'd4) ? d + 4'd3 : d;
  endfunction

endpackage
`default_nettype wire

// File: design/ita_dab.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ita_dab: bit-serial binary to BCD converter
// Shift-and-add-3, one magnitude bit per cycle.
// ----------------------------------------------------------------------------
module ita_dab import ita_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [VAL_W-1:0] mag_i,
  output logic                  done_o,
  output logic [BCD_W-1:0]      bcd_o
);

  logic             busy_q;
  logic             done_q;
  logic [4:0]       cnt_q;
  logic [VAL_W-1:0] bin_q;
  logic [BCD_W-1:0] bcd_q;
  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int i = 0; i < BCD_W / 4; i++) begin
      adj[i*4 +: 4] = bcd_adj(bcd_q[i*4 +: 4]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= mag_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[VAL_W-2:0], 1'b0};
      bcd_q <= {adj[BCD_W-2:0], bin_q[VAL_W-1]};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule
`default_nettype wire

// File: design/ita_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ita_emit: character sequencer
// Walks sign, prefix, digit shift register and suffix; one char per cycle
// while the output is not stalled and no leading zero is skipped, into a registered output stage.
// ----------------------------------------------------------------------------
module ita_emit import ita_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire emit_cmd_t cmd_i,
  output logic           busy_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output rsp_t           out_data_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SIGN = 3'd1;
  localparam logic [2:0] PH_PFX0 = 3'd2;
  localparam logic [2:0] PH_PFX1 = 3'd3;
  localparam logic [2:0] PH_BODY = 3'd4;
  localparam logic [2:0] PH_SUF0 = 3'd5;
  localparam logic [2:0] PH_SUF1 = 3'd6;

  logic [2:0]       ph_q;
  logic [BCD_W-1:0] sr_q;
  logic [CNT_W-1:0] cnt_q;
  logic [1:0]       kind_q;
  logic [1:0]       suf_q;
  logic             lead_q;
  logic             out_valid_q;
  rsp_t             out_q;

  logic [3:0] dig;
  logic [6:0] body_ch;
  logic [6:0] ch;
  logic [2:0] nxt;
  logic [2:0] after_body;
  logic [2:0] start_ph;
  logic       skip;
  logic       slot_free;
  logic       fire;
  logic       adv;

  always_comb begin
    dig        = (kind_q == KIND_BIN) ? {3'b000, sr_q[BCD_W-1]} : sr_q[BCD_W-1 -: 4];
    body_ch    = (dig > 4'd9) ? {3'b000, dig} + CH_ALPHA_OFS : {3'b000, dig} + CH_ZERO;
    after_body = (suf_q == SUF_NONE) ? PH_IDLE : PH_SUF0;
    skip       = (ph_q == PH_BODY) && (kind_q == KIND_DEC) && lead_q &&
                 (sr_q[BCD_W-1 -: 4] == 4'd0) && (cnt_q != 6'd1);
    start_ph   = cmd_i.neg ? PH_SIGN : ((cmd_i.kind == KIND_DEC) ? PH_BODY : PH_PFX0);
    ch         = CH_ZERO;
    nxt        = PH_IDLE;
    case (ph_q)
      PH_SIGN: begin
        ch  = CH_MINUS;
        nxt = PH_BODY;
      end
      PH_PFX0: begin
        ch  = CH_ZERO;
        nxt = PH_PFX1;
      end
      PH_PFX1: begin
        ch  = (kind_q == KIND_HEX) ? CH_X : CH_B;
        nxt = PH_BODY;
      end
      PH_BODY: begin
        ch  = body_ch;
        nxt = (cnt_q == 6'd1) ? after_body : PH_BODY;
      end
      PH_SUF0: begin
        case (suf_q)
          SUF_CRLF:  ch = CH_CR;
          SUF_SPACE: ch = CH_SPACE;
          default:   ch = CH_COMMA;
        endcase
        nxt = (suf_q == SUF_CRLF) ? PH_SUF1 : PH_IDLE;
      end
      PH_SUF1: begin
        ch  = CH_LF;
        nxt = PH_IDLE;
      end
      default: begin
        ch  = CH_ZERO;
        nxt = PH_IDLE;
      end
    endcase
    slot_free = !out_valid_q || !out_stall_i;
    fire      = (ph_q != PH_IDLE) && !skip && slot_free;
    adv       = fire || skip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        ph_q <= start_ph;
      end else if (adv) begin
        ph_q <= nxt;
      end
      if (slot_free) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sr_q   <= cmd_i.body;
      cnt_q  <= cmd_i.cnt;
      kind_q <= cmd_i.kind;
      suf_q  <= cmd_i.suffix;
      lead_q <= 1'b1;
    end else if (adv && (ph_q == PH_BODY)) begin
      sr_q   <= (kind_q == KIND_BIN) ? {sr_q[BCD_W-2:0], 1'b0} : {sr_q[BCD_W-5:0], 4'h0};
      cnt_q  <= cnt_q - 6'd1;
      lead_q <= skip;
    end
    if (fire) begin
      out_q.char_code <= ch;
      out_q.is_final  <= (nxt == PH_IDLE);
    end
  end

  assign busy_o      = (ph_q != PH_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: design/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: 32-bit value to ASCII text
// Formats one request as signed decimal, 0x hex or 0b binary plus an optional suffix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one request:
//   kind, value, suffix. Output channel (out_valid_o / out_stall_i /
//   out_data_o) delivers one ASCII char per transfer, is_final set on the
//   last char of the request. Kind 3 is taken and produces nothing.
//   Hex/binary: acceptance loads the sequencer, which then registers the first
//   char into the output register, then one char per cycle when not stalled.
//   Decimal: a bit-serial BCD converter runs first, then the sequencer skips
//   leading zero digits without emitting them, then emits the remaining digits.
//   A new request is accepted once the converter and the sequencer are idle;
//   the last char may still sit in the output register at that point.
//   A stalled receiver freezes the output register and the sequencer, though
//   the sequencer still skips leading zero digits while the output is stalled.
//   Reset clears the sequencer, converter and output valid; no text is
//   pending afterwards.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter import ita_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output rsp_t      out_data_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CONV = 1'b1;

  logic             state_q;
  logic [1:0]       suf_q;
  logic             neg_q;
  logic             accept;
  logic             emit_busy;
  logic             dab_done;
  logic             dab_start;
  logic [VAL_W-1:0] mag;
  logic [BCD_W-1:0] bcd;
  logic [VAL_W-1:0] aligned;
  logic [CNT_W-1:0] raw_cnt;
  logic             is_dec;
  logic             is_raw;
  logic             val_neg;
  emit_cmd_t        emit_cmd;

  assign in_stall_o = (state_q != ST_IDLE) || emit_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_dec     = (in_data_i.kind == KIND_DEC);
  assign is_raw     = (in_data_i.kind == KIND_HEX) || (in_data_i.kind == KIND_BIN);
  assign val_neg    = in_data_i.value[VAL_W-1];
  assign mag        = val_neg ? (~in_data_i.value + 32'd1) : in_data_i.value;
  assign dab_start  = accept && is_dec;

  always_comb begin
    if (in_data_i.value <= 32'h0000_00FF) begin
      aligned = {in_data_i.value[7:0], 24'h0};
      raw_cnt = (in_data_i.kind == KIND_HEX) ? 6'd2 : 6'd8;
    end else if (in_data_i.value <= 32'h0000_FFFF) begin
      aligned = {in_data_i.value[15:0], 16'h0};
      raw_cnt = (in_data_i.kind == KIND_HEX) ? 6'd4 : 6'd16;
    end else begin
      aligned = in_data_i.value;
      raw_cnt = (in_data_i.kind == KIND_HEX) ? 6'd8 : 6'd32;
    end
  end

  always_comb begin
    if (state_q == ST_CONV) begin
      emit_cmd.start  = dab_done;
      emit_cmd.kind   = KIND_DEC;
      emit_cmd.suffix = suf_q;
      emit_cmd.neg    = neg_q;
      emit_cmd.body   = bcd;
      emit_cmd.cnt    = 6'd10;
    end else begin
      emit_cmd.start  = accept && is_raw;
      emit_cmd.kind   = in_data_i.kind;
      emit_cmd.suffix = in_data_i.suffix;
      emit_cmd.neg    = 1'b0;
      emit_cmd.body   = {aligned, 8'h00};
      emit_cmd.cnt    = raw_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: if (dab_start) state_q <= ST_CONV;
        ST_CONV: if (dab_done)  state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (dab_start) begin
      suf_q <= in_data_i.suffix;
      neg_q <= val_neg;
    end
  end

  ita_dab u_dab (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dab_start),
    .mag_i   (mag),
    .done_o  (dab_done),
    .bcd_o   (bcd)
  );

  ita_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (emit_cmd),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_conv_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((state_q == ST_CONV) && emit_busy))
    else $error("sequencer busy during decimal conversion");

  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dab_done |-> (state_q == ST_CONV))
    else $error("conversion done outside conversion state");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_cmd.start |=> emit_busy)
    else $error("sequencer did not start");
`endif

endmodule
`default_nettype wire
